// ===== rtl/shape_overlap_test_2d_defines.svh =====
// assertion macros for the shape overlap test block
// used by shape_overlap_test_2d; expects clk and arst_n in scope
`ifndef SHAPE_OVERLAP_TEST_2D_DEFINES_SVH
`define SHAPE_OVERLAP_TEST_2D_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SOTD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define SOTD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/sotd_pkg.sv =====
// shared types for the shape overlap test pipeline
// no dependencies
package sotd_pkg;

	// shape pair selector carried on tuser
	typedef enum logic [1:0] {
		MODE_RR = 2'd0,  // rect - rect
		MODE_CC = 2'd1,  // circle - circle
		MODE_RC = 2'd2,  // rect (left) - circle (right)
		MODE_CR = 2'd3   // circle (left) - rect (right)
	} mode_t;

endpackage

// ===== rtl/sotd_diff.sv =====
// stage 1: centre distance magnitudes, size sums and shape role selection
// depends on sotd_pkg
module sotd_diff import sotd_pkg::*; #(
	parameter int COORD_BITS = 24
) (
	input  logic                         clk,
	input  logic                         adv,
	input  mode_t                        mode,
	input  logic signed [COORD_BITS-1:0] left_x,
	input  logic signed [COORD_BITS-1:0] left_y,
	input  logic        [COORD_BITS-2:0] left_w,
	input  logic        [COORD_BITS-2:0] left_h,
	input  logic signed [COORD_BITS-1:0] right_x,
	input  logic signed [COORD_BITS-1:0] right_y,
	input  logic        [COORD_BITS-2:0] right_w,
	input  logic        [COORD_BITS-2:0] right_h,
	output mode_t                        mode_s1,
	output logic        [COORD_BITS-1:0] ax_s1,
	output logic        [COORD_BITS-1:0] ay_s1,
	output logic        [COORD_BITS-1:0] sw_s1,
	output logic        [COORD_BITS-1:0] sh_s1,
	output logic        [COORD_BITS-2:0] rw_s1,
	output logic        [COORD_BITS-2:0] rh_s1,
	output logic        [COORD_BITS-2:0] dm_s1
);

	localparam int W = COORD_BITS;

	logic signed [W:0]   dx, dy;
	logic        [W:0]   ndx, ndy;
	logic        [W-1:0] ax, ay;
	logic                rect_left;

	assign dx  = {left_x[W-1], left_x} - {right_x[W-1], right_x};
	assign dy  = {left_y[W-1], left_y} - {right_y[W-1], right_y};
	assign ndx = -dx;
	assign ndy = -dy;
	// magnitude of a difference of two W-bit values fits in W bits
	assign ax  = dx[W] ? ndx[W-1:0] : dx[W-1:0];
	assign ay  = dy[W] ? ndy[W-1:0] : dy[W-1:0];

	assign rect_left = (mode == MODE_RC);

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1 <= mode;
			ax_s1   <= ax;
			ay_s1   <= ay;
			sw_s1   <= {1'b0, left_w} + {1'b0, right_w};
			sh_s1   <= {1'b0, left_h} + {1'b0, right_h};
			rw_s1   <= rect_left ? left_w  : right_w;
			rh_s1   <= rect_left ? left_h  : right_h;
			dm_s1   <= rect_left ? right_w : left_w;
		end
	end

endmodule

// ===== rtl/sotd_sel.sv =====
// stage 2: inclusive box compares and choice of the circle test operands
// depends on sotd_pkg
module sotd_sel import sotd_pkg::*; #(
	parameter int COORD_BITS = 24
) (
	input  logic                  clk,
	input  logic                  adv,
	input  mode_t                 mode_s1,
	input  logic [COORD_BITS-1:0] ax_s1,
	input  logic [COORD_BITS-1:0] ay_s1,
	input  logic [COORD_BITS-1:0] sw_s1,
	input  logic [COORD_BITS-1:0] sh_s1,
	input  logic [COORD_BITS-2:0] rw_s1,
	input  logic [COORD_BITS-2:0] rh_s1,
	input  logic [COORD_BITS-2:0] dm_s1,
	output logic                  box_s2,
	output logic [COORD_BITS:0]   a_s2,
	output logic [COORD_BITS:0]   b_s2,
	output logic [COORD_BITS-1:0] lim_s2
);

	localparam int W = COORD_BITS;

	logic [W:0]   ap, aq;
	logic [W-1:0] rw_d, rh_d;
	logic [W+1:0] ex, ey, nex, ney;
	logic [W:0]   cx, cy;
	logic         rr_box, cr_box;
	logic         box;
	logic [W:0]   a, b;
	logic [W-1:0] lim;

	// doubled centre offsets keep every half-size compare exact
	assign ap = {ax_s1, 1'b0};
	assign aq = {ay_s1, 1'b0};

	assign rw_d = {1'b0, rw_s1} + {1'b0, dm_s1};
	assign rh_d = {1'b0, rh_s1} + {1'b0, dm_s1};

	assign rr_box = (ap <= {1'b0, sw_s1}) && (aq <= {1'b0, sh_s1});
	assign cr_box = ((ap <= {1'b0, rw_d}) && (aq <= {2'b00, rh_s1})) ||
	                ((ap <= {2'b00, rw_s1}) && (aq <= {1'b0, rh_d}));

	// distance from the nearest corner, per axis
	assign ex  = {1'b0, ap} - {3'b000, rw_s1};
	assign ey  = {1'b0, aq} - {3'b000, rh_s1};
	assign nex = -ex;
	assign ney = -ey;
	assign cx  = ex[W+1] ? nex[W:0] : ex[W:0];
	assign cy  = ey[W+1] ? ney[W:0] : ey[W:0];

	always_comb begin
		unique case (mode_s1)
			MODE_RR: begin
				box = rr_box;
				a   = ap;
				b   = aq;
				lim = '0;
			end
			MODE_CC: begin
				box = 1'b0;
				a   = ap;
				b   = aq;
				lim = sw_s1;
			end
			default: begin
				box = cr_box;
				a   = cx;
				b   = cy;
				lim = {1'b0, dm_s1};
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			box_s2 <= box;
			a_s2   <= a;
			b_s2   <= b;
			lim_s2 <= lim;
		end
	end

endmodule

// ===== rtl/sotd_sq.sv =====
// stage 3: three parallel squarers for the circle distance test
// depends on sotd_pkg
module sotd_sq import sotd_pkg::*; #(
	parameter int COORD_BITS = 24
) (
	input  logic                      clk,
	input  logic                      adv,
	input  logic                      box_s2,
	input  logic [COORD_BITS:0]       a_s2,
	input  logic [COORD_BITS:0]       b_s2,
	input  logic [COORD_BITS-1:0]     lim_s2,
	output logic                      box_s3,
	output logic [2*COORD_BITS+1:0]   asq_s3,
	output logic [2*COORD_BITS+1:0]   bsq_s3,
	output logic [2*COORD_BITS-1:0]   lsq_s3
);

	localparam int W = COORD_BITS;

	logic [2*W+1:0] a_x, b_x;
	logic [2*W-1:0] l_x;

	assign a_x = {{(W+1){1'b0}}, a_s2};
	assign b_x = {{(W+1){1'b0}}, b_s2};
	assign l_x = {{W{1'b0}}, lim_s2};

	always_ff @(posedge clk) begin
		if (adv) begin
			box_s3 <= box_s2;
			asq_s3 <= a_x * a_x;
			bsq_s3 <= b_x * b_x;
			lsq_s3 <= l_x * l_x;
		end
	end

endmodule

// ===== rtl/shape_overlap_test_2d.sv =====
// top level of the 2-d shape overlap test: stream ports, valid/ready chain, final compare
// depends on sotd_pkg, sotd_diff, sotd_sel, sotd_sq and shape_overlap_test_2d_defines.svh
//
// one shape pair enters per transaction and yields exactly one hit transaction. the pair is
// selected by s_tuser: rect-rect, circle-circle, rect-circle or circle-rect, with centres
// in signed q16.8 and full sizes in unsigned q15.8 (y grows downward, a circle uses its
// width as diameter). rect overlap and the widened/heightened rect tests are inclusive;
// circle tests are strict and compare squared distances against squared radii, exactly,
// on doubled coordinates. the datapath is a four-stage pipeline (distance and size sums,
// box compares and operand choice, squarers, sum and compare) that accepts a new pair
// every clock while m_tready is high; each pair passes through the stage 1 to 4 registers
// in order, and stage 4 drives m_tvalid and m_tdata. each stage holds its own valid bit
// and only stalls when the stage after it is full, so bubbles close up under back-pressure
// and nothing is dropped or repeated. the squarer stage, at about (COORD_BITS+1) x
// (COORD_BITS+1) bits, sets the clock period. no state carries between pairs.
`include "shape_overlap_test_2d_defines.svh"

module shape_overlap_test_2d import sotd_pkg::*; #(
	parameter int COORD_BITS = 24
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// input stream
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// fields, lsb first: left_x, left_y, left_w, left_h, right_x, right_y, right_w, right_h
	input  logic [((8*COORD_BITS-4)+7)/8*8-1:0]    s_tdata,
	// fields, lsb first: mode
	input  logic [1:0]                             s_tuser,
	// result stream
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// fields, lsb first: hit
	output logic [7:0]                             m_tdata
);

	localparam int W = COORD_BITS;

	// field offsets inside s_tdata
	localparam int LX_LO = 0;
	localparam int LY_LO = LX_LO + W;
	localparam int LW_LO = LY_LO + W;
	localparam int LH_LO = LW_LO + W - 1;
	localparam int RX_LO = LH_LO + W - 1;
	localparam int RY_LO = RX_LO + W;
	localparam int RW_LO = RY_LO + W;
	localparam int RH_LO = RW_LO + W - 1;

	// unpacked input fields
	mode_t               in_mode;
	logic signed [W-1:0] in_lx, in_ly, in_rx, in_ry;
	logic        [W-2:0] in_lw, in_lh, in_rw, in_rh;

	assign in_mode = mode_t'(s_tuser);
	assign in_lx   = s_tdata[LX_LO +: W];
	assign in_ly   = s_tdata[LY_LO +: W];
	assign in_lw   = s_tdata[LW_LO +: W-1];
	assign in_lh   = s_tdata[LH_LO +: W-1];
	assign in_rx   = s_tdata[RX_LO +: W];
	assign in_ry   = s_tdata[RY_LO +: W];
	assign in_rw   = s_tdata[RW_LO +: W-1];
	assign in_rh   = s_tdata[RH_LO +: W-1];

	// per-stage valid bits and the ready chain; a stage loads when it is empty or its
	// successor is loading
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	assign rdy4 = !v_s4 || m_tready;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;

	assign s_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// stage 1: distances, sums and shape roles
	mode_t        mode_s1;
	logic [W-1:0] ax_s1, ay_s1, sw_s1, sh_s1;
	logic [W-2:0] rw_s1, rh_s1, dm_s1;

	sotd_diff #(.COORD_BITS(COORD_BITS)) u_diff (
		.clk     (clk),
		.adv     (rdy1),
		.mode    (in_mode),
		.left_x  (in_lx),
		.left_y  (in_ly),
		.left_w  (in_lw),
		.left_h  (in_lh),
		.right_x (in_rx),
		.right_y (in_ry),
		.right_w (in_rw),
		.right_h (in_rh),
		.mode_s1 (mode_s1),
		.ax_s1   (ax_s1),
		.ay_s1   (ay_s1),
		.sw_s1   (sw_s1),
		.sh_s1   (sh_s1),
		.rw_s1   (rw_s1),
		.rh_s1   (rh_s1),
		.dm_s1   (dm_s1)
	);

	// stage 2: box compares and circle operands
	logic         box_s2;
	logic [W:0]   a_s2, b_s2;
	logic [W-1:0] lim_s2;

	sotd_sel #(.COORD_BITS(COORD_BITS)) u_sel (
		.clk     (clk),
		.adv     (rdy2),
		.mode_s1 (mode_s1),
		.ax_s1   (ax_s1),
		.ay_s1   (ay_s1),
		.sw_s1   (sw_s1),
		.sh_s1   (sh_s1),
		.rw_s1   (rw_s1),
		.rh_s1   (rh_s1),
		.dm_s1   (dm_s1),
		.box_s2  (box_s2),
		.a_s2    (a_s2),
		.b_s2    (b_s2),
		.lim_s2  (lim_s2)
	);

	// stage 3: squares
	logic           box_s3;
	logic [2*W+1:0] asq_s3, bsq_s3;
	logic [2*W-1:0] lsq_s3;

	sotd_sq #(.COORD_BITS(COORD_BITS)) u_sq (
		.clk    (clk),
		.adv    (rdy3),
		.box_s2 (box_s2),
		.a_s2   (a_s2),
		.b_s2   (b_s2),
		.lim_s2 (lim_s2),
		.box_s3 (box_s3),
		.asq_s3 (asq_s3),
		.bsq_s3 (bsq_s3),
		.lsq_s3 (lsq_s3)
	);

	// stage 4: distance sum against squared limit, strict; this is the output register
	logic [2*W+2:0] dsq;
	logic           circ_hit;
	logic           hit_s4;

	assign dsq      = {1'b0, asq_s3} + {1'b0, bsq_s3};
	assign circ_hit = dsq < {3'b000, lsq_s3};

	always_ff @(posedge clk) begin
		if (rdy4) begin
			hit_s4 <= box_s3 || circ_hit;
		end
	end

	assign m_tvalid = v_s4;
	assign m_tdata  = {7'b0000000, hit_s4};

	// a free output side never blocks the input side
	`SOTD_ASSERT_NOW(a_no_block, m_tready, s_tready, "input stalled with output ready")
	// a stalled stage 3 keeps its item, asq_s3 and lsq_s3
	`SOTD_ASSERT_NEXT(a_s3_hold, v_s3 && !rdy3, v_s3 && $stable(asq_s3) && $stable(lsq_s3),
		"stage 3 lost data during stall")
	// a zero limit with no box hit can never report a hit
	`SOTD_ASSERT_NEXT(a_zero_lim, v_s3 && rdy4 && !box_s3 && (lsq_s3 == '0), !m_tdata[0],
		"hit reported with zero circle limit")

endmodule

// ===== bench/tb_shape_overlap_test_2d.sv =====
// self-checking bench for shape_overlap_test_2d: directed table then ~1300 random pairs,
// random gaps on both stream sides, one long sink hold-off, scoreboard against a local model
// depends on sotd_pkg and the rtl of shape_overlap_test_2d
module tb_shape_overlap_test_2d import sotd_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int COORD_BITS   = 24;
	localparam int TDATA_W      = ((8*COORD_BITS-4)+7)/8*8;
	localparam int RANDOM_PAIRS = 1300;
	localparam int IDLE_LIMIT   = 5000;  // cycles with no transaction on either side
	localparam int HOLD_CYCLES  = 300;   // long sink hold-off to back up the pipeline
	localparam int HOLD_AFTER   = 200;   // results seen before the hold-off starts
	localparam int DRAIN_CYCLES = 12;    // pipeline is 4 deep, give it some slack
	localparam int PREDICT      = -1;    // table row has no typed-in answer

	// one shape pair as carried by a transaction
	typedef struct {
		mode_t                         mode;
		logic signed [COORD_BITS-1:0]  lx, ly;
		logic        [COORD_BITS-2:0]  lw, lh;
		logic signed [COORD_BITS-1:0]  rx, ry;
		logic        [COORD_BITS-2:0]  rw, rh;
	} pair_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	// fields, lsb first: left_x, left_y, left_w, left_h, right_x, right_y, right_w, right_h
	logic [TDATA_W-1:0] s_tdata = '0;
	// fields, lsb first: mode
	logic [1:0]         s_tuser = MODE_RR;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	// fields, lsb first: hit
	logic [7:0]         m_tdata;

	shape_overlap_test_2d #(.COORD_BITS(COORD_BITS)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// directed table, one row per pair
	pair_t pair_table[$];
	int    pair_want[$];

	// hit flags still owed by the block, oldest first
	bit    hit_expected[$];
	int    mismatch_count = 0;
	int    hits_seen = 0;
	bit    stimulus_done = 1'b0;

	// ---------------------------------------------------------------- overlap model
	// everything runs on doubled coordinates so half sizes never round

	function automatic longint mag64(longint v);
		return (v < 0) ? -v : v;
	endfunction

	// strict: dx^2 + dy^2 < lim^2
	function automatic bit inside_radius(longint dx, longint dy, longint lim);
		return (dx*dx + dy*dy) < (lim*lim);
	endfunction

	// inclusive axis-aligned box overlap
	function automatic bit box_overlap(longint x1, longint y1, longint w1, longint h1,
			longint x2, longint y2, longint w2, longint h2);
		return mag64(2*(x1 - x2)) <= (w1 + w2) && mag64(2*(y1 - y2)) <= (h1 + h2);
	endfunction

	// circle (centre, diameter) against box (centre, full size)
	function automatic bit disc_box(longint cx, longint cy, longint d,
			longint bx, longint by, longint bw, longint bh);
		longint p, q;
		int     sx, sy;
		p = 2*(cx - bx);
		q = 2*(cy - by);
		// centre inside the box grown by the radius along one axis
		if (mag64(p) <= bw + d && mag64(q) <= bh)
			return 1'b1;
		if (mag64(p) <= bw && mag64(q) <= bh + d)
			return 1'b1;
		// otherwise only a corner can reach the circle
		for (sx = -1; sx <= 1; sx += 2)
			for (sy = -1; sy <= 1; sy += 2)
				if (inside_radius(p - sx*bw, q - sy*bh, d))
					return 1'b1;
		return 1'b0;
	endfunction

	function automatic bit overlap_hit(pair_t t);
		longint lx, ly, lw, lh, rx, ry, rw, rh;
		bit     hit;
		lx = longint'(t.lx); ly = longint'(t.ly); lw = longint'(t.lw); lh = longint'(t.lh);
		rx = longint'(t.rx); ry = longint'(t.ry); rw = longint'(t.rw); rh = longint'(t.rh);
		case (t.mode)
			MODE_RR: hit = box_overlap(lx, ly, lw, lh, rx, ry, rw, rh);
			MODE_CC: hit = inside_radius(2*(lx - rx), 2*(ly - ry), lw + rw);
			MODE_RC: hit = disc_box(rx, ry, rw, lx, ly, lw, lh);
			default: hit = disc_box(lx, ly, lw, rx, ry, rw, rh);
		endcase
		return hit;
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	function automatic logic [TDATA_W-1:0] pack_pair(pair_t t);
		return TDATA_W'({t.rh, t.rw, t.ry, t.rx, t.lh, t.lw, t.ly, t.lx});
	endfunction

	function automatic void add_row(mode_t m, int lx, int ly, int lw, int lh,
			int rx, int ry, int rw, int rh, int want);
		pair_t t;
		t.mode = m;
		t.lx = COORD_BITS'(lx); t.ly = COORD_BITS'(ly);
		t.lw = (COORD_BITS-1)'(lw); t.lh = (COORD_BITS-1)'(lh);
		t.rx = COORD_BITS'(rx); t.ry = COORD_BITS'(ry);
		t.rw = (COORD_BITS-1)'(rw); t.rh = (COORD_BITS-1)'(rh);
		pair_table.push_back(t);
		pair_want.push_back(want);
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// small sizes dominate, zero and full-range ones show up too
	function automatic logic [COORD_BITS-2:0] rand_size();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		else if (r == 1)
			return (COORD_BITS-1)'($urandom);
		else if (r < 6)
			return (COORD_BITS-1)'($urandom_range(0, 4096));
		return (COORD_BITS-1)'($urandom_range(0, 1 << 18));
	endfunction

	// most pairs sit close enough that the answer depends on the boundary
	function automatic pair_t rand_pair();
		pair_t  t;
		int     kind;
		longint spanx, spany, dx, dy;
		t.mode = mode_t'($urandom_range(0, 3));
		t.lx = COORD_BITS'($urandom); t.ly = COORD_BITS'($urandom);
		t.lw = rand_size(); t.lh = rand_size();
		t.rw = rand_size(); t.rh = rand_size();
		kind = $urandom_range(0, 9);
		if (kind < 2) begin
			// far apart or anywhere: exercises every coordinate bit
			t.rx = COORD_BITS'($urandom);
			t.ry = COORD_BITS'($urandom);
		end else begin
			spanx = (longint'(t.lw) + t.rw) / 2;
			case (t.mode)
				MODE_RR: spany = (longint'(t.lh) + t.rh) / 2;
				MODE_CC: spany = spanx;
				MODE_RC: spany = (longint'(t.lh) + t.rw) / 2;
				default: spany = (longint'(t.lw) + t.rh) / 2;
			endcase
			// kind 2 puts the centres exactly at the touching distance in x
			dx = (kind == 2) ? spanx : $urandom_range(0, int'(spanx + spanx/4 + 2));
			dy = $urandom_range(0, int'(spany + spany/4 + 2));
			if ($urandom_range(0, 1))
				dx = -dx;
			if ($urandom_range(0, 1))
				dy = -dy;
			t.rx = COORD_BITS'(longint'(t.lx) + dx);
			t.ry = COORD_BITS'(longint'(t.ly) + dy);
		end
		return t;
	endfunction

	// ---------------------------------------------------------------- clock and reset

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// ---------------------------------------------------------------- directed table

	initial begin
		// rect-rect: zero-size boxes behave as points
		add_row(MODE_RR, 0, 0, 0, 0, 0, 0, 0, 0, 1);
		// rect-rect: touching edges count as a hit
		add_row(MODE_RR, 0, 0, 512, 512, 512, 0, 512, 512, 1);
		add_row(MODE_RR, 0, 0, 512, 512, 513, 0, 512, 512, 0);
		add_row(MODE_RR, 0, 0, 512, 512, 0, -512, 512, 512, 1);
		// rect-rect: opposite coordinate extremes, largest sizes
		add_row(MODE_RR, -8388608, -8388608, 8388607, 8388607,
			8388607, 8388607, 8388607, 8388607, 0);
		add_row(MODE_RR, 8388607, 8388607, 8388607, 8388607,
			8388607, 8388607, 8388607, 8388607, 1);
		// circle-circle: zero diameters never hit, even coincident
		add_row(MODE_CC, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		// circle-circle: touching is a miss, one lsb closer is a hit
		add_row(MODE_CC, 0, 0, 512, 0, 512, 0, 512, 0, 0);
		add_row(MODE_CC, 0, 0, 512, 0, 511, 0, 512, 0, 1);
		// circle-circle: heights are ignored
		add_row(MODE_CC, 0, 0, 512, 8388607, 511, 0, 512, 8388607, 1);
		add_row(MODE_CC, -8388608, -8388608, 8388607, 0, 8388607, 8388607, 8388607, 0, 0);
		add_row(MODE_CC, -8388608, 8388607, 8388607, 0, -8388608, 8388607, 8388607, 0, 1);
		// circle-rect: centre right on the widened edge hits, one lsb out misses
		add_row(MODE_CR, 0, 0, 256, 0, 384, 0, 512, 512, 1);
		add_row(MODE_CR, 0, 0, 256, 0, 385, 0, 512, 512, 0);
		// rect-circle: centre right on the heightened edge
		add_row(MODE_RC, 0, 0, 512, 512, 0, 384, 256, 0, 1);
		// corner region: too small a circle misses, a bigger one reaches the corner
		add_row(MODE_CR, 0, 0, 256, 0, 384, 384, 512, 512, 0);
		add_row(MODE_CR, 0, 0, 512, 0, 384, 384, 512, 512, 1);
		// point rect against circles, including a zero-diameter one
		add_row(MODE_RC, 100, 0, 0, 0, 0, 0, 256, 0, 1);
		add_row(MODE_RC, 0, 0, 0, 0, 0, 0, 0, 0, 1);
		// extremes where the answer needs the full computation
		add_row(MODE_CR, -8388608, 8388607, 8388607, 0,
			8388607, -8388608, 8388607, 8388607, PREDICT);
		add_row(MODE_RC, 8388607, -8388608, 8388607, 8388607,
			-8388608, -8388608, 8388607, 8388607, PREDICT);
		add_row(MODE_RR, -1, -1, 8388607, 1, 0, 0, 1, 8388607, PREDICT);
		add_row(MODE_CC, 1000, -2000, 3000, 77, -1500, 1200, 4000, 5, PREDICT);
		add_row(MODE_CR, 5000, 5000, 1000, 8388607, 5400, 4300, 300, 900, PREDICT);
	end

	// ---------------------------------------------------------------- source side

	initial begin : pair_source
		pair_t t;
		int    idx, gap, total;
		bit    want;
		wait (arst_n === 1'b1);
		@(negedge clk);
		total = pair_table.size() + RANDOM_PAIRS;
		for (idx = 0; idx < total; idx++) begin
			if (idx < pair_table.size()) begin
				t = pair_table[idx];
				want = (pair_want[idx] == PREDICT) ? overlap_hit(t) : pair_want[idx][0];
			end else begin
				t = rand_pair();
				want = overlap_hit(t);
			end
			// every fourth block of 100 pairs streams back to back
			gap = ((idx / 100) % 4 == 3) ? 0 : pick_gap();
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata  <= pack_pair(t);
			s_tuser  <= t.mode;
			do @(posedge clk); while (!s_tready);
			hit_expected.push_back(want);
			@(negedge clk);
		end
		s_tvalid <= 1'b0;
		stimulus_done = 1'b1;
	end

	// ---------------------------------------------------------------- sink side

	initial begin : result_sink
		int run, stall;
		bit held = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			// one long hold-off so the pipeline fills and stalls the source
			if (!held && hits_seen >= HOLD_AFTER) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			run   = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 4);
			stall = pick_gap();
			m_tready <= 1'b1;
			repeat (run) @(negedge clk);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
		end
	end

	// ---------------------------------------------------------------- result check

	always @(posedge clk) begin : hit_check
		bit want;
		if (arst_n && m_tvalid && m_tready) begin
			hits_seen++;
			if (hit_expected.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: unexpected result transaction, hit=%0b", $realtime,
						m_tdata[0]);
			end else begin
				want = hit_expected.pop_front();
				if (m_tdata[0] !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: result %0d hit expected %0b got %0b", $realtime,
							hits_seen, want, m_tdata[0]);
				end
			end
		end
	end

	// ---------------------------------------------------------------- watchdog

	initial begin : watchdog
		int idle;
		idle = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle = 0;
			else
				idle++;
			if (idle >= IDLE_LIMIT) begin
				$display("tb_shape_overlap_test_2d: errors");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------- end of run

	initial begin : verdict
		wait (stimulus_done);
		while (hit_expected.size() != 0)
			@(posedge clk);
		// catch any stray result that trails the last expected one
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && hit_expected.size() == 0)
			$display("tb_shape_overlap_test_2d: clean");
		else
			$display("tb_shape_overlap_test_2d: errors");
		$finish;
	end

endmodule
